### src/rpn_pkg.sv
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared types and constants of the RPN stack evaluator.
// ----------------------------------------------------------------------------
package rpn_pkg;

	localparam int STACK_DEPTH = 32;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

	localparam int DATA_W      = 32;
	localparam int OP_W        = 3;
	localparam int DIGIT_W     = 4;
	localparam int STATUS_W    = 3;

	localparam int DIV_STEPS   = DATA_W;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

	// Queue between front and back; power of two so the pointers wrap freely
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

	// Token codes on the input channel
	localparam logic [OP_W-1:0] OP_DIGIT = 3'd0;
	localparam logic [OP_W-1:0] OP_ADD   = 3'd1;
	localparam logic [OP_W-1:0] OP_SUB   = 3'd2;
	localparam logic [OP_W-1:0] OP_MUL   = 3'd3;
	localparam logic [OP_W-1:0] OP_DIV   = 3'd4;

	localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FEW      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_DIVZERO  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_COUNT    = 3'd4;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd5;

	typedef enum logic [2:0] {
		K_PUSH,
		K_ADD,
		K_SUB,
		K_MUL,
		K_DIV,
		K_BAD
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [DIGIT_W-1:0] digit;
		logic               last;
	} cmd_t;

endpackage

### src/rpn_if.sv
// ----------------------------------------------------------------------------
// rpn_in_if / rpn_out_if
// Valid/ready channels for tokens in and results out.
// ----------------------------------------------------------------------------
interface rpn_in_if;
	logic                        valid;
	logic                        ready;
	logic [rpn_pkg::OP_W-1:0]    op;
	logic [rpn_pkg::DIGIT_W-1:0] digit;
	logic                        last;

	modport source (output valid, output op, output digit, output last, input ready);
	modport sink   (input valid, input op, input digit, input last, output ready);
endinterface

interface rpn_out_if;
	logic                         valid;
	logic                         ready;
	logic signed [rpn_pkg::DATA_W-1:0] value;
	logic [rpn_pkg::STATUS_W-1:0] status;

	modport source (output valid, output value, output status, input ready);
	modport sink   (input valid, input value, input status, output ready);
endinterface

### src/rpn_stack_evaluator_core.sv
// ----------------------------------------------------------------------------
// rpn_stack_evaluator_core
// Reverse Polish notation evaluator: tokens in, one result per expression out.
// ----------------------------------------------------------------------------
// A digit token passes through the idle and finish states of the back end. An
// add, subtract or multiply also reads two operands, executes and writes back,
// and a divide also waits on the bit-per-cycle divider; the single read port of
// the operand stack RAM fetches the two operands one after the other. A token
// marked last adds a state in which the final value is read back from the stack. A
// two-entry queue lets the front take tokens while the back is busy, and the
// result sits in an output register so the next expression keeps flowing
// while it waits to be taken.
module rpn_stack_evaluator_core (
	input  logic        clk,
	input  logic        arst_n,
	rpn_in_if.sink      tok,
	rpn_out_if.source   res
);

	rpn_pkg::cmd_t cmd;
	logic          cmd_valid;
	logic          cmd_pop;

	rpn_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok       (tok),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop)
	);

	rpn_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.res       (res)
	);

endmodule

### src/rpn_ram.sv
// ----------------------------------------------------------------------------
// rpn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rpn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### src/rpn_div.sv
// ----------------------------------------------------------------------------
// rpn_div
// Signed 32-bit divider, truncating toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rpn_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [rpn_pkg::DATA_W-1:0] dividend,
	input  logic [rpn_pkg::DATA_W-1:0] divisor,
	output logic                       done,
	output logic [rpn_pkg::DATA_W-1:0] quot
);

	localparam int W = rpn_pkg::DATA_W;

	logic                            busy_q;
	logic [rpn_pkg::DIV_CNT_W-1:0]   cnt_q;
	logic [W-1:0]                    rem_q;
	logic [W-1:0]                    quo_q;
	logic [W-1:0]                    dvs_q;
	logic                            neg_q;
	logic [W:0]                      trial;

	// Restoring step: shift in the next dividend bit and try the subtract
	assign trial = {rem_q, quo_q[W-1]} - {1'b0, dvs_q};
	assign done  = busy_q && (cnt_q == '0);
	assign quot  = neg_q ? (W'(0) - quo_q) : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= rpn_pkg::DIV_CNT_W'(rpn_pkg::DIV_STEPS);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend[W-1] ? (W'(0) - dividend) : dividend;
			dvs_q <= divisor[W-1] ? (W'(0) - divisor) : divisor;
			rem_q <= '0;
			neg_q <= dividend[W-1] ^ divisor[W-1];
		end else if (busy_q && (cnt_q != '0)) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[W-2:0], quo_q[W-1]};
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

endmodule

### src/rpn_front.sv
// ----------------------------------------------------------------------------
// rpn_front
// Accepts tokens, classifies them into commands and queues them for the back.
// ----------------------------------------------------------------------------
module rpn_front (
	input  logic           clk,
	input  logic           arst_n,
	rpn_in_if.sink         tok,
	output rpn_pkg::cmd_t  cmd,
	output logic           cmd_valid,
	input  logic           cmd_pop
);

	rpn_pkg::cmd_t                 q_mem [rpn_pkg::QUEUE_DEPTH];
	logic [rpn_pkg::QPTR_W-1:0]    wptr_q;
	logic [rpn_pkg::QPTR_W-1:0]    rptr_q;
	logic [rpn_pkg::QFILL_W-1:0]   fill_q;
	rpn_pkg::cmd_t                 cls;
	logic                          push;
	logic                          pop;

	always_comb begin
		cls.digit = tok.digit;
		cls.last  = tok.last;
		unique case (tok.op)
			rpn_pkg::OP_DIGIT: cls.kind = (tok.digit > rpn_pkg::DIGIT_MAX) ?
				rpn_pkg::K_BAD : rpn_pkg::K_PUSH;
			rpn_pkg::OP_ADD:   cls.kind = rpn_pkg::K_ADD;
			rpn_pkg::OP_SUB:   cls.kind = rpn_pkg::K_SUB;
			rpn_pkg::OP_MUL:   cls.kind = rpn_pkg::K_MUL;
			rpn_pkg::OP_DIV:   cls.kind = rpn_pkg::K_DIV;
			default:           cls.kind = rpn_pkg::K_BAD;
		endcase
	end

	assign tok.ready = (fill_q != rpn_pkg::QFILL_W'(rpn_pkg::QUEUE_DEPTH));
	assign push      = tok.valid && tok.ready;
	assign cmd_valid = (fill_q != '0);
	assign pop       = cmd_pop && cmd_valid;
	assign cmd       = q_mem[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			fill_q <= fill_q + rpn_pkg::QFILL_W'(push) - rpn_pkg::QFILL_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wptr_q] <= cls;
		end
	end

endmodule

### src/rpn_back.sv
// ----------------------------------------------------------------------------
// rpn_back
// Executes queued commands against the operand stack and emits results.
// ----------------------------------------------------------------------------
module rpn_back (
	input  logic           clk,
	input  logic           arst_n,
	input  rpn_pkg::cmd_t  cmd,
	input  logic           cmd_valid,
	output logic           cmd_pop,
	rpn_out_if.source      res
);

	localparam int W  = rpn_pkg::DATA_W;
	localparam int AW = rpn_pkg::ADDR_W;
	localparam int CW = rpn_pkg::CNT_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RDR  = 3'd1;
	localparam logic [2:0] S_RDL  = 3'd2;
	localparam logic [2:0] S_EXEC = 3'd3;
	localparam logic [2:0] S_DIVW = 3'd4;
	localparam logic [2:0] S_WR   = 3'd5;
	localparam logic [2:0] S_FIN  = 3'd6;
	localparam logic [2:0] S_RD0  = 3'd7;

	logic [2:0]                     state_q;
	logic [CW-1:0]                  count_q;
	logic [rpn_pkg::STATUS_W-1:0]   err_q;
	rpn_pkg::kind_t                 kind_q;
	logic                           last_q;
	logic [W-1:0]                   r_q;
	logic [W-1:0]                   l_q;
	logic [W-1:0]                   res_q;
	logic                           out_valid_q;
	logic [W-1:0]                   out_value_q;
	logic [rpn_pkg::STATUS_W-1:0]   out_status_q;

	logic [CW-1:0]                  cnt_m1;
	logic [CW-1:0]                  cnt_m2;
	logic                           slot_free;
	logic                           bad_final;
	logic                           out_load;
	logic [W-1:0]                   out_value;
	logic [rpn_pkg::STATUS_W-1:0]   out_status;
	logic                           ram_we;
	logic [AW-1:0]                  ram_waddr;
	logic [W-1:0]                   ram_wdata;
	logic [AW-1:0]                  ram_raddr;
	logic [W-1:0]                   ram_rdata;
	logic                           div_start;
	logic                           div_done;
	logic [W-1:0]                   div_quot;

	rpn_ram #(
		.WIDTH (W),
		.DEPTH (rpn_pkg::STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	rpn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (l_q),
		.divisor  (r_q),
		.done     (div_done),
		.quot     (div_quot)
	);

	assign cnt_m1    = count_q - CW'(1);
	assign cnt_m2    = count_q - CW'(2);
	assign slot_free = !out_valid_q || res.ready;
	assign bad_final = (err_q != rpn_pkg::ST_OK) || (count_q != CW'(1));
	assign cmd_pop   = (state_q == S_IDLE) && cmd_valid;
	assign div_start = (state_q == S_EXEC) && (kind_q == rpn_pkg::K_DIV) && (r_q != '0);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[AW-1:0];
		ram_wdata = {{(W-rpn_pkg::DIGIT_W){1'b0}}, cmd.digit};
		ram_raddr = '0;
		out_load  = 1'b0;
		out_value = '0;
		out_status = (err_q != rpn_pkg::ST_OK) ? err_q : rpn_pkg::ST_COUNT;
		unique case (state_q)
			S_IDLE: begin
				ram_raddr = cnt_m1[AW-1:0];
				ram_we    = cmd_valid && (err_q == rpn_pkg::ST_OK) &&
					(cmd.kind == rpn_pkg::K_PUSH) && (count_q < CW'(rpn_pkg::STACK_DEPTH));
			end
			S_RDR: ram_raddr = cnt_m2[AW-1:0];
			S_WR: begin
				ram_we    = 1'b1;
				ram_waddr = cnt_m2[AW-1:0];
				ram_wdata = res_q;
			end
			S_FIN: out_load = last_q && bad_final && slot_free;
			S_RD0: begin
				out_load   = slot_free;
				out_value  = ram_rdata;
				out_status = rpn_pkg::ST_OK;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			err_q       <= rpn_pkg::ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						state_q <= S_FIN;
						if (err_q == rpn_pkg::ST_OK) begin
							unique case (cmd.kind)
								rpn_pkg::K_PUSH: begin
									if (count_q >= CW'(rpn_pkg::STACK_DEPTH)) begin
										err_q <= rpn_pkg::ST_OVERFLOW;
									end else begin
										count_q <= count_q + 1'b1;
									end
								end
								rpn_pkg::K_BAD: err_q <= rpn_pkg::ST_INVALID;
								default: begin
									if (count_q < CW'(2)) begin
										err_q <= rpn_pkg::ST_FEW;
									end else begin
										state_q <= S_RDR;
									end
								end
							endcase
						end
					end
				end
				S_RDR: state_q <= S_RDL;
				S_RDL: state_q <= S_EXEC;
				S_EXEC: begin
					if (kind_q == rpn_pkg::K_DIV) begin
						if (r_q == '0) begin
							err_q   <= rpn_pkg::ST_DIVZERO;
							state_q <= S_FIN;
						end else begin
							state_q <= S_DIVW;
						end
					end else begin
						state_q <= S_WR;
					end
				end
				S_DIVW: begin
					if (div_done) begin
						state_q <= S_WR;
					end
				end
				S_WR: begin
					count_q <= cnt_m1;
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!last_q) begin
						state_q <= S_IDLE;
					end else if (!bad_final) begin
						state_q <= S_RD0;
					end else if (slot_free) begin
						count_q <= '0;
						err_q   <= rpn_pkg::ST_OK;
						state_q <= S_IDLE;
					end
				end
				S_RD0: begin
					if (slot_free) begin
						count_q <= '0;
						err_q   <= rpn_pkg::ST_OK;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			kind_q <= cmd.kind;
			last_q <= cmd.last;
		end
		if (state_q == S_RDR) begin
			r_q <= ram_rdata;
		end
		if (state_q == S_RDL) begin
			l_q <= ram_rdata;
		end
		if (state_q == S_EXEC) begin
			unique case (kind_q)
				rpn_pkg::K_ADD: res_q <= l_q + r_q;
				rpn_pkg::K_SUB: res_q <= l_q - r_q;
				rpn_pkg::K_MUL: res_q <= l_q * r_q;
				default:        res_q <= res_q;
			endcase
		end else if ((state_q == S_DIVW) && div_done) begin
			res_q <= div_quot;
		end
		if (out_load) begin
			out_value_q  <= out_value;
			out_status_q <= out_status;
		end
	end

	assign res.valid  = out_valid_q;
	assign res.value  = out_value_q;
	assign res.status = out_status_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(rpn_pkg::STACK_DEPTH))
		else $error("stack count beyond depth");

	a_clear_after_report: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (count_q == '0) && (err_q == rpn_pkg::ST_OK))
		else $error("state not cleared after final report");

	a_err_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_status_q != rpn_pkg::ST_OK)) |-> (out_value_q == '0))
		else $error("error result carries a value");

	a_div_start_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> (state_q == S_DIVW) && (r_q != '0))
		else $error("divider started without entering wait");

	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |=> (state_q == S_FIN) || (state_q == S_RDR))
		else $error("command taken outside idle");

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives token streams into the RPN evaluator and checks every result against
// a cycle-free model of the operand stack and its sticky error. A short table
// of hand-picked tokens comes first. Random expressions follow: well-formed,
// deep, corrupted, min-by-minus-one and pure noise. Both channels idle in
// random bursts, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;

	localparam logic [rpn_pkg::OP_W-1:0] OP_BAD    = 3'd5;
	localparam logic [rpn_pkg::OP_W-1:0] OP_SPARE6 = 3'd6;
	localparam logic [rpn_pkg::OP_W-1:0] OP_SPARE7 = 3'd7;

	localparam int RANDOM_TOKENS = 700;
	localparam int QUIET_TAIL    = 120;
	localparam int HOLD_CYCLES   = 400;
	localparam int DRAIN_CYCLES  = 60;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int REPORT_MAX    = 10;

	typedef struct packed {
		logic [rpn_pkg::DATA_W-1:0]   value;
		logic [rpn_pkg::STATUS_W-1:0] status;
	} result_t;

	typedef struct packed {
		logic [rpn_pkg::OP_W-1:0]     op;
		logic [rpn_pkg::DIGIT_W-1:0]  digit;
		logic                         last;
		bit                           typed;
		logic [rpn_pkg::DATA_W-1:0]   value;
		logic [rpn_pkg::STATUS_W-1:0] status;
	} script_row_t;

	logic clk;
	logic arst_n;

	rpn_in_if  tok_if ();
	rpn_out_if res_if ();

	rpn_stack_evaluator_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.tok    (tok_if),
		.res    (res_if)
	);

	// Model state of the evaluator
	logic [rpn_pkg::DATA_W-1:0]   calc_stack [rpn_pkg::STACK_DEPTH];
	int                           calc_depth = 0;
	logic [rpn_pkg::STATUS_W-1:0] calc_err   = rpn_pkg::ST_OK;

	result_t pending_results [$];
	int      bad_results   = 0;
	int      tokens_sent   = 0;
	int      cycle_count   = 0;
	bit      send_gaps_on  = 1'b0;
	bit      sink_gaps_on  = 1'b0;
	bit      quiet         = 1'b0;
	bit      hold_req      = 1'b0;

	script_row_t script [28] = '{
		'{rpn_pkg::OP_DIGIT, 4'd9,  1'b1, 1'b1, 32'd9, rpn_pkg::ST_OK},
		'{rpn_pkg::OP_DIGIT, 4'd0,  1'b1, 1'b1, 32'd0, rpn_pkg::ST_OK},
		'{rpn_pkg::OP_DIGIT, 4'd15, 1'b1, 1'b1, 32'd0, rpn_pkg::ST_INVALID},
		'{OP_SPARE7,         4'd0,  1'b1, 1'b1, 32'd0, rpn_pkg::ST_INVALID},
		'{rpn_pkg::OP_ADD,   4'd0,  1'b1, 1'b1, 32'd0, rpn_pkg::ST_FEW},
		'{rpn_pkg::OP_DIGIT, 4'd5,  1'b0, 1'b0, 32'd0, rpn_pkg::ST_OK},
		'{rpn_pkg::OP_DIGIT, 4'd0,  1'b0, 1'b0, 32'd0, rpn_pkg::ST_OK},
		'{rpn_pkg::OP_DIV,   4'd0,  1'b1, 1'b1, 32'd0, rpn_pkg::ST_DIVZERO},
		'{rpn_pkg::OP_DIGIT, 4'd3,  1'b0, 1'b0, 32'd0, rpn_pkg::ST_OK},
		'{rpn_pkg::OP_DIGIT, 4'd4,  1'b1, 1'b1, 32'd0, rpn_pkg::ST_COUNT},
		'{rpn_pkg::OP_DIGIT, 4'd9,  1'b0, 1'b0, 32'd0, rpn_pkg::ST_OK},
		'{rpn_pkg::OP_DIGIT, 4'd9,  1'b0, 1'b0, 32'd0, rpn_pkg::ST_OK},
		'{rpn_pkg::OP_ADD,   4'd0,  1'b1, 1'b0, 32'd0, rpn_pkg::ST_OK},
		'{rpn_pkg::OP_DIGIT, 4'd2,  1'b0, 1'b0, 32'd0, rpn_pkg::ST_OK},
		'{rpn_pkg::OP_DIGIT, 4'd7,  1'b0, 1'b0, 32'd0, rpn_pkg::ST_OK},
		'{rpn_pkg::OP_SUB,   4'd0,  1'b0, 1'b0, 32'd0, rpn_pkg::ST_OK},
		'{rpn_pkg::OP_DIGIT, 4'd9,  1'b0, 1'b0, 32'd0, rpn_pkg::ST_OK},
		'{rpn_pkg::OP_MUL,   4'd0,  1'b1, 1'b0, 32'd0, rpn_pkg::ST_OK},
		'{rpn_pkg::OP_DIGIT, 4'd0,  1'b0, 1'b0, 32'd0, rpn_pkg::ST_OK},
		'{rpn_pkg::OP_DIGIT, 4'd7,  1'b0, 1'b0, 32'd0, rpn_pkg::ST_OK},
		'{rpn_pkg::OP_SUB,   4'd0,  1'b0, 1'b0, 32'd0, rpn_pkg::ST_OK},
		'{rpn_pkg::OP_DIGIT, 4'd2,  1'b0, 1'b0, 32'd0, rpn_pkg::ST_OK},
		'{rpn_pkg::OP_DIV,   4'd0,  1'b1, 1'b0, 32'd0, rpn_pkg::ST_OK},
		'{rpn_pkg::OP_DIGIT, 4'd1,  1'b0, 1'b0, 32'd0, rpn_pkg::ST_OK},
		'{OP_BAD,            4'd8,  1'b0, 1'b0, 32'd0, rpn_pkg::ST_OK},
		'{rpn_pkg::OP_DIGIT, 4'd2,  1'b0, 1'b0, 32'd0, rpn_pkg::ST_OK},
		'{rpn_pkg::OP_ADD,   4'd0,  1'b1, 1'b1, 32'd0, rpn_pkg::ST_INVALID},
		'{OP_SPARE6,         4'd10, 1'b1, 1'b1, 32'd0, rpn_pkg::ST_INVALID}
	};

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Apply one token to the model stack; return 1 with the report on last
	function automatic bit rpn_apply(input logic [rpn_pkg::OP_W-1:0] op,
			input logic [rpn_pkg::DIGIT_W-1:0] digit, input logic last,
			output result_t rep);
		logic [rpn_pkg::DATA_W-1:0] lhs, rhs, acc, lmag, rmag;
		rep = '0;
		acc = '0;
		if (calc_err == rpn_pkg::ST_OK) begin
			if (op == rpn_pkg::OP_DIGIT) begin
				if (digit > rpn_pkg::DIGIT_MAX)
					calc_err = rpn_pkg::ST_INVALID;
				else if (calc_depth >= rpn_pkg::STACK_DEPTH)
					calc_err = rpn_pkg::ST_OVERFLOW;
				else begin
					calc_stack[calc_depth] = rpn_pkg::DATA_W'(digit);
					calc_depth++;
				end
			end else if (op > rpn_pkg::OP_DIV) begin
				calc_err = rpn_pkg::ST_INVALID;
			end else if (calc_depth < 2) begin
				calc_err = rpn_pkg::ST_FEW;
			end else begin
				rhs = calc_stack[calc_depth - 1];
				lhs = calc_stack[calc_depth - 2];
				case (op)
					rpn_pkg::OP_ADD: acc = lhs + rhs;
					rpn_pkg::OP_SUB: acc = lhs - rhs;
					rpn_pkg::OP_MUL: acc = lhs * rhs;
					default: begin
						// divide magnitudes, then fix the sign: truncates toward zero
						if (rhs != '0) begin
							lmag = lhs[rpn_pkg::DATA_W-1] ? -lhs : lhs;
							rmag = rhs[rpn_pkg::DATA_W-1] ? -rhs : rhs;
							acc  = lmag / rmag;
							if (lhs[rpn_pkg::DATA_W-1] ^ rhs[rpn_pkg::DATA_W-1])
								acc = -acc;
						end
					end
				endcase
				if (op == rpn_pkg::OP_DIV && rhs == '0)
					calc_err = rpn_pkg::ST_DIVZERO;
				else begin
					calc_depth--;
					calc_stack[calc_depth - 1] = acc;
				end
			end
		end
		if (!last)
			return 1'b0;
		if (calc_err != rpn_pkg::ST_OK)
			rep.status = calc_err;
		else if (calc_depth != 1)
			rep.status = rpn_pkg::ST_COUNT;
		else begin
			rep.status = rpn_pkg::ST_OK;
			rep.value  = calc_stack[0];
		end
		calc_depth = 0;
		calc_err   = rpn_pkg::ST_OK;
		return 1'b1;
	endfunction

	// Offer one request and hold it until taken; log what it must produce
	task automatic put_token(input logic [rpn_pkg::OP_W-1:0] op,
			input logic [rpn_pkg::DIGIT_W-1:0] digit, input logic last,
			input bit typed = 1'b0, input logic [rpn_pkg::DATA_W-1:0] tv = '0,
			input logic [rpn_pkg::STATUS_W-1:0] ts = '0);
		result_t rep;
		if (send_gaps_on && !quiet && $urandom_range(0, 4) == 0) begin
			@(negedge clk);
			tok_if.valid <= 1'b0;
			repeat ($urandom_range(0, 7)) @(negedge clk);
		end
		@(negedge clk);
		tok_if.valid <= 1'b1;
		tok_if.op    <= op;
		tok_if.digit <= digit;
		tok_if.last  <= last;
		do @(posedge clk); while (!tok_if.ready);
		if (rpn_apply(op, digit, last, rep)) begin
			if (typed) begin
				rep.value  = tv;
				rep.status = ts;
			end
			pending_results.push_back(rep);
		end
		tokens_sent++;
	endtask

	// Random well-formed expression; with mangle set, some tokens get corrupted
	task automatic send_expression(input int operands, input bit mangle);
		int pushed, depth;
		bit finish;
		logic [rpn_pkg::OP_W-1:0] op;
		logic [rpn_pkg::DIGIT_W-1:0] digit;
		pushed = 0;
		depth  = 0;
		finish = 1'b0;
		while (!finish) begin
			if (depth >= 2 && (pushed == operands || $urandom_range(0, 2) == 0)) begin
				op    = rpn_pkg::OP_W'($urandom_range(int'(rpn_pkg::OP_ADD),
					int'(rpn_pkg::OP_DIV)));
				digit = rpn_pkg::DIGIT_W'($urandom_range(0, 15));
				depth--;
			end else begin
				op    = rpn_pkg::OP_DIGIT;
				digit = rpn_pkg::DIGIT_W'($urandom_range(0, 9));
				pushed++;
				depth++;
			end
			if (mangle && $urandom_range(0, 5) == 0) begin
				op    = rpn_pkg::OP_W'($urandom_range(0, 7));
				digit = rpn_pkg::DIGIT_W'($urandom_range(0, 15));
			end
			finish = (pushed == operands && depth == 1);
			put_token(op, digit, finish);
		end
	endtask

	// Fill the stack to around its depth, then fold it back with operators
	task automatic send_deep_stack();
		int n;
		n = $urandom_range(rpn_pkg::STACK_DEPTH - 2, rpn_pkg::STACK_DEPTH + 3);
		for (int i = 0; i < n; i++)
			put_token(rpn_pkg::OP_DIGIT, rpn_pkg::DIGIT_W'($urandom_range(0, 9)), 1'b0);
		for (int i = 1; i < n; i++)
			put_token(rpn_pkg::OP_W'($urandom_range(int'(rpn_pkg::OP_ADD),
				int'(rpn_pkg::OP_MUL))),
				rpn_pkg::DIGIT_W'($urandom_range(0, 15)), i == n - 1);
	endtask

	// Build 2^31, which wraps to -2^31 (the most negative value), from digits, then divide it by -1
	task automatic send_min_by_minus_one();
		put_token(rpn_pkg::OP_DIGIT, 4'd8, 1'b0);
		repeat (9) begin
			put_token(rpn_pkg::OP_DIGIT, 4'd8, 1'b0);
			put_token(rpn_pkg::OP_MUL, 4'd0, 1'b0);
		end
		put_token(rpn_pkg::OP_DIGIT, 4'd2, 1'b0);
		put_token(rpn_pkg::OP_MUL, 4'd0, 1'b0);
		put_token(rpn_pkg::OP_DIGIT, 4'd0, 1'b0);
		put_token(rpn_pkg::OP_DIGIT, 4'd1, 1'b0);
		put_token(rpn_pkg::OP_SUB, 4'd0, 1'b0);
		put_token(rpn_pkg::OP_DIV, 4'd0, 1'b1);
	endtask

	task automatic send_noise();
		int len;
		len = $urandom_range(1, 6);
		for (int i = 0; i < len; i++)
			put_token(rpn_pkg::OP_W'($urandom_range(0, 7)),
				rpn_pkg::DIGIT_W'($urandom_range(0, 15)), i == len - 1);
	endtask

	// Result side: random back-pressure and one long hold-off on request
	initial begin
		res_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				res_if.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else if (sink_gaps_on && !quiet && $urandom_range(0, 5) == 0) begin
				res_if.ready <= 1'b0;
				repeat ($urandom_range(0, 7)) @(negedge clk);
			end else begin
				res_if.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (pending_results.size() == 0) begin
				bad_results++;
				if (bad_results <= REPORT_MAX)
					$display("unexpected result: value %0d status %0d",
						res_if.value, res_if.status);
			end else begin
				want = pending_results.pop_front();
				if (res_if.value !== want.value || res_if.status !== want.status) begin
					bad_results++;
					if (bad_results <= REPORT_MAX)
						$display("mismatch: value exp %0d got %0d, status exp %0d got %0d",
							$signed(want.value), res_if.value, want.status, res_if.status);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		int seq_no;
		int pick;
		arst_n       = 1'b0;
		tok_if.valid = 1'b0;
		tok_if.op    = rpn_pkg::OP_DIGIT;
		tok_if.digit = '0;
		tok_if.last  = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (script[i])
			put_token(script[i].op, script[i].digit, script[i].last,
				script[i].typed, script[i].value, script[i].status);

		// Short expressions back to back while the result side holds off, then the random mix
		hold_req = 1'b1;
		seq_no   = 0;
		while (tokens_sent < $size(script) + RANDOM_TOKENS) begin
			quiet        = tokens_sent > $size(script) + RANDOM_TOKENS - QUIET_TAIL;
			send_gaps_on = seq_no >= 30 && $urandom_range(0, 3) != 0;
			sink_gaps_on = $urandom_range(0, 3) != 0;
			pick         = (seq_no < 30) ? 0 : $urandom_range(0, 99);
			if (pick < 55)
				send_expression(($urandom_range(0, 7) == 0) ? $urandom_range(9, 20)
					: $urandom_range(1, 8), 1'b0);
			else if (pick < 62)
				send_deep_stack();
			else if (pick < 65)
				send_min_by_minus_one();
			else if (pick < 82)
				send_expression($urandom_range(1, 8), 1'b1);
			else
				send_noise();
			seq_no++;
		end
		@(negedge clk);
		tok_if.valid <= 1'b0;
		tok_if.last  <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (bad_results == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

### rpn_stack_evaluator_core.f
src/rpn_pkg.sv
src/rpn_if.sv
src/rpn_ram.sv
src/rpn_div.sv
src/rpn_front.sv
src/rpn_back.sv
src/rpn_stack_evaluator_core.sv
dv/tb_top.sv
